### src/m4inv_pkg.sv
`timescale 1ns / 1ps
package m4inv_pkg;

  localparam int M4_FRAC_BITS = 16;
  localparam int M4_WORD_BITS = 32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_XLD,
    S_MLD,
    S_MRUN,
    S_ACC,
    S_DCHK,
    S_DNEG,
    S_NLD,
    S_DIV,
    S_OUT,
    S_SING
  } m4_state_t;

  // Row or column k of a 3x3 minor, mapped back into the 4x4 matrix.
  function automatic logic [1:0] minor_map(input logic [1:0] k, input logic [1:0] skip);
    logic [1:0] res;
    res = (k >= skip) ? k + 2'd1 : k;
    return res;
  endfunction

  // Column taken by factor k of the six terms of a 3x3 determinant.
  function automatic logic [1:0] term_col(input logic [2:0] term, input logic [1:0] k);
    logic [5:0] perm;
    case (term)
      3'd0:    perm = {2'd2, 2'd1, 2'd0};
      3'd1:    perm = {2'd1, 2'd2, 2'd0};
      3'd2:    perm = {2'd2, 2'd0, 2'd1};
      3'd3:    perm = {2'd0, 2'd2, 2'd1};
      3'd4:    perm = {2'd1, 2'd0, 2'd2};
      3'd5:    perm = {2'd0, 2'd1, 2'd2};
      default: perm = {2'd2, 2'd1, 2'd0};
    endcase
    return perm[{k, 1'b0} +: 2];
  endfunction

  function automatic logic term_minus(input logic [2:0] term);
    return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
  endfunction

  // Matrix index of factor k of a term of cofactor cof (minor skips row c, column r).
  function automatic logic [3:0] factor_idx(input logic [3:0] cof, input logic [2:0] term,
                                            input logic [1:0] k);
    logic [1:0] row;
    logic [1:0] col;
    row = minor_map(k, cof[1:0]);
    col = minor_map(term_col(term, k), cof[3:2]);
    return {row, col};
  endfunction

endpackage

### src/matrix4_inverse.sv
`timescale 1ns / 1ps
// Channel  Ports                                                     Direction
// in_      in_valid, in_stall, in_element_value                      request in
// out_     out_valid, out_stall, out_inverse_value, out_element_index,
//          out_singular, out_last                                    request out
//
// Sixteen requests load the matrix, one cycle each.
// After the 16th, one shared adder runs bit-serial multiplies for the adjugate and
// determinant, then restoring division for each inverse element.
// Input is stalled until the last result leaves.
// Synchronous reset clears the sequencer and the load count; out_stall holds a result.
module matrix4_inverse
  import m4inv_pkg::*;
#(
  parameter int FRAC_BITS = M4_FRAC_BITS,
  parameter int WORD_BITS = M4_WORD_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_element_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_inverse_value,
  output logic [3:0]  out_element_index,
  output logic        out_singular,
  output logic        out_last
);

  localparam int W  = WORD_BITS;
  localparam int AW = 3 * W + 3;
  localparam int DW = 4 * W + 5;
  localparam int NW = AW + 2 * FRAC_BITS;
  localparam int CW = $clog2(NW);

  m4_state_t state_r, state_nxt;

  logic [3:0]    load_cnt_r, load_cnt_nxt;
  logic [3:0]    cof_r, cof_nxt;
  logic [2:0]    term_r, term_nxt;
  logic          phase_r, phase_nxt;
  logic          det_mode_r, det_mode_nxt;
  logic [CW-1:0] bit_cnt_r, bit_cnt_nxt;

  logic [W-1:0]  mat_r [16];
  logic [AW-1:0] adj_r [16];

  logic [DW-1:0] x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [DW-1:0] prod_r, prod_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [W:0]    q_r, q_nxt;
  logic          ovf_r, ovf_nxt;
  logic          det_neg_r, det_neg_nxt;
  logic          q_neg_r, q_neg_nxt;

  logic          mat_we;
  logic          adj_we;
  logic [3:0]    mat_idx;
  logic [3:0]    adj_idx;
  logic [W-1:0]  mat_rd;
  logic [AW-1:0] adj_rd;

  // shared adder: opa + (inv ? ~opb + 1 : opb), with carry out
  logic [DW:0]   opa, opb;
  logic          inv;
  logic [DW+1:0] add_sum;

  logic [DW:0]   rem_s;
  logic          odd;
  logic          big_pos, big_neg;
  logic [W-1:0]  res;

  assign add_sum = {1'b0, opa} + {1'b0, opb ^ {(DW + 1){inv}}} + {{(DW + 1){1'b0}}, inv};

  assign mat_rd = mat_r[mat_idx];
  assign adj_rd = adj_r[adj_idx];
  assign odd    = cof_r[0] ^ cof_r[2];
  assign rem_s  = {rem_r, dvd_r[NW-1]};

  always_comb begin
    mat_idx = factor_idx(cof_r, term_r, 2'd0);
    if (state_r == S_MLD) begin
      if (det_mode_r) begin
        mat_idx = {2'b00, cof_r[1:0]};
      end else begin
        mat_idx = factor_idx(cof_r, term_r, phase_r ? 2'd2 : 2'd1);
      end
    end
    adj_idx = det_mode_r ? {cof_r[1:0], 2'b00} : cof_r;
  end

  // saturate the quotient magnitude to the signed word range
  always_comb begin
    big_pos = ovf_r | q_r[W] | q_r[W-1];
    big_neg = ovf_r | q_r[W] | (q_r[W-1] & (|q_r[W-2:0]));
    if (q_neg_r) begin
      res = big_neg ? {1'b1, {(W - 1){1'b0}}} : (~q_r[W-1:0] + W'(1));
    end else begin
      res = big_pos ? {1'b0, {(W - 1){1'b1}}} : q_r[W-1:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    cof_nxt      = cof_r;
    term_nxt     = term_r;
    phase_nxt    = phase_r;
    det_mode_nxt = det_mode_r;
    bit_cnt_nxt  = bit_cnt_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    den_nxt      = den_r;
    rem_nxt      = rem_r;
    dvd_nxt      = dvd_r;
    q_nxt        = q_r;
    ovf_nxt      = ovf_r;
    det_neg_nxt  = det_neg_r;
    q_neg_nxt    = q_neg_r;
    mat_we       = 1'b0;
    adj_we       = 1'b0;
    opa          = '0;
    opb          = '0;
    inv          = 1'b0;

    in_stall          = 1'b1;
    out_valid         = 1'b0;
    out_inverse_value = 32'(signed'(res));
    out_element_index = cof_r;
    out_singular      = 1'b0;
    out_last          = (cof_r == 4'd15);

    case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          mat_we       = 1'b1;
          load_cnt_nxt = load_cnt_r + 4'd1;
          if (load_cnt_r == 4'd15) begin
            cof_nxt      = '0;
            term_nxt     = '0;
            phase_nxt    = 1'b0;
            det_mode_nxt = 1'b0;
            acc_nxt      = '0;
            state_nxt    = S_XLD;
          end
        end
      end
      S_XLD: begin
        x_nxt     = DW'(signed'(mat_rd));
        state_nxt = S_MLD;
      end
      S_MLD: begin
        y_nxt       = mat_rd;
        prod_nxt    = '0;
        bit_cnt_nxt = CW'(W - 1);
        if (det_mode_r) begin
          x_nxt = DW'(signed'(adj_rd));
        end else if (phase_r) begin
          x_nxt = prod_r;
        end
        state_nxt = S_MRUN;
      end
      S_MRUN: begin
        // MSB first; the sign bit of y carries negative weight
        opa         = {prod_r, 1'b0};
        opb         = y_r[W-1] ? {x_r[DW-1], x_r} : '0;
        inv         = (bit_cnt_r == CW'(W - 1));
        prod_nxt    = add_sum[DW-1:0];
        y_nxt       = {y_r[W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - CW'(1);
        if (bit_cnt_r == '0) begin
          if (!det_mode_r && !phase_r) begin
            phase_nxt = 1'b1;
            state_nxt = S_MLD;
          end else begin
            state_nxt = S_ACC;
          end
        end
      end
      S_ACC: begin
        opa       = {acc_r[DW-1], acc_r};
        opb       = {prod_r[DW-1], prod_r};
        inv       = det_mode_r ? 1'b0 : (term_minus(term_r) ^ odd);
        acc_nxt   = add_sum[DW-1:0];
        phase_nxt = 1'b0;
        if (det_mode_r) begin
          if (cof_r == 4'd3) begin
            state_nxt = S_DCHK;
          end else begin
            cof_nxt   = cof_r + 4'd1;
            state_nxt = S_MLD;
          end
        end else if (term_r == 3'd5) begin
          // cofactor complete: store it and start the next one, or the determinant after the last
          adj_we   = 1'b1;
          acc_nxt  = '0;
          term_nxt = '0;
          if (cof_r == 4'd15) begin
            det_mode_nxt = 1'b1;
            cof_nxt      = '0;
            state_nxt    = S_MLD;
          end else begin
            cof_nxt   = cof_r + 4'd1;
            state_nxt = S_XLD;
          end
        end else begin
          term_nxt  = term_r + 3'd1;
          state_nxt = S_XLD;
        end
      end
      S_DCHK: begin
        state_nxt = (acc_r == '0) ? S_SING : S_DNEG;
      end
      S_DNEG: begin
        opb          = {acc_r[DW-1], acc_r};
        inv          = acc_r[DW-1];
        den_nxt      = add_sum[DW-1:0];
        det_neg_nxt  = acc_r[DW-1];
        det_mode_nxt = 1'b0;
        cof_nxt      = '0;
        state_nxt    = S_NLD;
      end
      S_NLD: begin
        opb         = DW'(signed'(adj_rd)) | {1'b0, {DW{1'b0}}} | {adj_rd[AW-1], {DW{1'b0}}};
        inv         = adj_rd[AW-1];
        dvd_nxt     = {add_sum[AW-1:0], {(2 * FRAC_BITS){1'b0}}};
        q_neg_nxt   = adj_rd[AW-1] ^ det_neg_r;
        rem_nxt     = '0;
        q_nxt       = '0;
        ovf_nxt     = 1'b0;
        bit_cnt_nxt = CW'(NW - 1);
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        opa         = rem_s;
        opb         = {1'b0, den_r};
        inv         = 1'b1;
        rem_nxt     = add_sum[DW+1] ? add_sum[DW-1:0] : rem_s[DW-1:0];
        q_nxt       = {q_r[W-1:0], add_sum[DW+1]};
        ovf_nxt     = ovf_r | q_r[W];
        dvd_nxt     = {dvd_r[NW-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - CW'(1);
        if (bit_cnt_r == '0) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (cof_r == 4'd15) begin
            state_nxt = S_LOAD;
          end else begin
            cof_nxt   = cof_r + 4'd1;
            state_nxt = S_NLD;
          end
        end
      end
      S_SING: begin
        out_valid         = 1'b1;
        out_inverse_value = '0;
        out_element_index = '0;
        out_singular      = 1'b1;
        out_last          = 1'b1;
        if (!out_stall) begin
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cof_r      <= cof_nxt;
    term_r     <= term_nxt;
    phase_r    <= phase_nxt;
    det_mode_r <= det_mode_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    q_r        <= q_nxt;
    ovf_r      <= ovf_nxt;
    det_neg_r  <= det_neg_nxt;
    q_neg_r    <= q_neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_r[load_cnt_r] <= in_element_value[W-1:0];
    end
    if (adj_we) begin
      adj_r[cof_r] <= add_sum[AW-1:0];
    end
  end

endmodule

### sim/tb_matrix4_inverse.sv
`timescale 1ns / 1ps
module tb_matrix4_inverse
  import m4inv_pkg::*;
();

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [31:0] inv_value;
    logic [3:0]  index;
    logic        singular;
    logic        last;
  } inv_result_t;

  class inverse_scoreboard;
    logic [31:0] mat[16];
    int          loaded;
    inv_result_t pending[$];
    int          errors;

    function new();
      loaded = 0;
      errors = 0;
    endfunction

    function wide_t elem(int idx);
      return wide_t'($signed(mat[idx]));
    endfunction

    // determinant of the 3x3 minor without row sr and column sc
    function wide_t minor3(int sr, int sc);
      int    r[3];
      int    c[3];
      int    n;
      wide_t e[3][3];
      n = 0;
      for (int i = 0; i < 4; i++) if (i != sr) begin r[n] = i; n++; end
      n = 0;
      for (int i = 0; i < 4; i++) if (i != sc) begin c[n] = i; n++; end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) e[i][j] = elem(r[i] * 4 + c[j]);
      return e[0][0] * e[1][1] * e[2][2] - e[0][0] * e[1][2] * e[2][1]
           - e[0][1] * e[1][0] * e[2][2] + e[0][1] * e[1][2] * e[2][0]
           + e[0][2] * e[1][0] * e[2][1] - e[0][2] * e[1][1] * e[2][0];
    endfunction

    function void note_element(logic [31:0] v);
      wide_t       adj[16];
      wide_t       det;
      wide_t       q;
      inv_result_t res;
      mat[loaded] = v;
      loaded++;
      if (loaded < 16) return;
      loaded = 0;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          adj[r * 4 + c] = minor3(c, r);
          if ((r + c) % 2 == 1) adj[r * 4 + c] = -adj[r * 4 + c];
        end
      det = 0;
      for (int j = 0; j < 4; j++) det = det + elem(j) * adj[j * 4];
      if (det == 0) begin
        res = '{32'd0, 4'd0, 1'b1, 1'b1};
        pending.push_back(res);
        return;
      end
      for (int j = 0; j < 16; j++) begin
        q = (adj[j] <<< (2 * M4_FRAC_BITS)) / det;
        if (q > wide_t'(32'sh7fffffff)) q = wide_t'(32'sh7fffffff);
        if (q < -wide_t'(64'sh80000000)) q = -wide_t'(64'sh80000000);
        res.inv_value = q[31:0];
        res.index     = j[3:0];
        res.singular  = 1'b0;
        res.last      = (j == 15);
        pending.push_back(res);
      end
    endfunction

    function void check_result(logic [31:0] v, logic [3:0] idx, logic sing, logic lst);
      inv_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result value=%h index=%0d", v, idx);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (v !== e.inv_value) begin
        $error("inverse_value expected %h actual %h", e.inv_value, v); errors++;
      end
      if (idx !== e.index) begin
        $error("element_index expected %0d actual %0d", e.index, idx); errors++;
      end
      if (sing !== e.singular) begin
        $error("singular expected %b actual %b", e.singular, sing); errors++;
      end
      if (lst !== e.last) begin
        $error("last expected %b actual %b", e.last, lst); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_element_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_inverse_value;
  logic [3:0]  out_element_index;
  logic        out_singular;
  logic        out_last;

  matrix4_inverse dut (.*);

  inverse_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;
  int  quiet_cycles;
  bit  accepted_now;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_element(logic [31:0] v);
    int gap;
    gap = 0;
    if (send_idle_pct > 0)
      while ($urandom_range(99) < send_idle_pct && gap < 8) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_element(v);
  endtask

  task automatic send_matrix(int kind);
    logic [31:0] m[16];
    int          dup_row;
    for (int i = 0; i < 16; i++) begin
      case (kind)
        0: m[i] = $urandom();
        1: m[i] = ((i % 5 == 0) ? 32'h0001_0000 : 32'h0)
                  + 32'($signed($urandom_range(8191)) - 4096);
        2: m[i] = (i % 5 == 0) ? 32'($urandom_range(7) + 1) : 32'h0;
        default: m[i] = $urandom() >> $urandom_range(31);
      endcase
    end
    // for kind 3, make the matrix singular by repeating a row
    dup_row = $urandom_range(1, 3);
    if (kind == 3)
      for (int c = 0; c < 4; c++) m[4 * dup_row + c] = m[c];
    for (int i = 0; i < 16; i++) send_element(m[i]);
  endtask

  // receiver: sample the pre-edge request, then decide the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_inverse_value, out_element_index, out_singular, out_last);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    accepted_now = (in_valid && !in_stall) || (out_valid && !out_stall);
    if (!rst_n || accepted_now) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 200000) begin
      $display("matrix4_inverse regression: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] ext[16];
    int          phase;
    sb               = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_element_value = 32'h0;
    out_stall        = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_cycles      = 0;
    quiet_cycles     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes: max on the diagonal, min and small values elsewhere
    for (int i = 0; i < 16; i++)
      ext[i] = (i % 5 == 0) ? 32'h7fffffff : ((i % 2) ? 32'h80000000 : 32'h1);
    for (int i = 0; i < 16; i++) send_element(ext[i]);
    // all-zero matrix: singular
    for (int i = 0; i < 16; i++) send_element(32'h0);

    for (int mtx = 0; mtx < 28; mtx++) begin
      phase = mtx % 4;
      send_idle_pct  = (phase == 1) ? 61 : (phase == 3) ? 35 : 0;
      recv_stall_pct = (phase == 2) ? 61 : (phase == 3) ? 35 : 0;
      // hold off the output long enough that the input backs up
      if (mtx == 5) hold_cycles <= 12000;
      send_matrix(mtx % 7 == 6 ? 2 : mtx % 5 == 4 ? 3 : mtx % 3);
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("matrix4_inverse regression: pass");
    end else begin
      $display("matrix4_inverse regression: fail");
    end
    $finish;
  end

endmodule
